[rtl/core/pikt_pkg.sv]
// shared types, constants and helpers for the pager keep-alive table
package pikt_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    localparam int FUNC_W   = 3;
    localparam int FREQ_W   = 32;
    localparam int KEY_W    = 16;
    localparam int CD_W     = 8;
    localparam int STATUS_W = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [FUNC_W-1:0] FN_INS_FLEX   = 3'd0;
    localparam logic [FUNC_W-1:0] FN_INS_POCSAG = 3'd1;
    localparam logic [FUNC_W-1:0] FN_ACTIVITY   = 3'd2;
    localparam logic [FUNC_W-1:0] FN_TICK       = 3'd3;
    localparam logic [FUNC_W-1:0] FN_QRY_FLEX   = 3'd4;
    localparam logic [FUNC_W-1:0] FN_QRY_POCSAG = 3'd5;
    localparam logic [FUNC_W-1:0] FN_NOP        = 3'd6;

    localparam logic [STATUS_W-1:0] STAT_OK     = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_DUP    = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_SYNCED = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_FULL   = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_NONE   = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_COLLAPSE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNCED_MODE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNCED_FREQ = 2'd2;

    localparam logic [CD_W-1:0]  FLEX_RELOAD   = 8'd127;
    localparam logic [CD_W-1:0]  POCSAG_RELOAD = 8'd128;
    localparam logic [KEY_W-1:0] KEY_SPLIT     = 16'd500;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } state_t;

    typedef struct packed {
        logic              valid;
        logic [KEY_W-1:0]  key;
        logic [FREQ_W-1:0] freq;
        logic [CD_W-1:0]   cd;
    } entry_t;

    typedef struct packed {
        logic dup;
        logic placed;
        logic found;
    } scan_t;

    function automatic logic [7:0] low_mask(input logic [2:0] collapse);
        return (8'd1 << collapse) - 8'd1;
    endfunction

endpackage

[rtl/core/pikt_in_if.sv]
// request channel: valid/ready with func, freq and key
interface pikt_in_if;
    logic                        valid;
    logic                        ready;
    logic [pikt_pkg::FUNC_W-1:0] func;
    logic [pikt_pkg::FREQ_W-1:0] freq;
    logic [pikt_pkg::KEY_W-1:0]  key;

    modport source (output valid, output func, output freq, output key, input ready);
    modport sink   (input valid, input func, input freq, input key, output ready);
endinterface

[rtl/core/pikt_out_if.sv]
// result channel: valid/ready with status, found_freq and found_key
interface pikt_out_if;
    logic                          valid;
    logic                          ready;
    logic [pikt_pkg::STATUS_W-1:0] status;
    logic [pikt_pkg::FREQ_W-1:0]   found_freq;
    logic [pikt_pkg::KEY_W-1:0]    found_key;

    modport source (output valid, output status, output found_freq, output found_key,
                    input ready);
    modport sink   (input valid, input status, input found_freq, input found_key,
                    output ready);
endinterface

[rtl/core/pikt_cell.sv]
// one table entry of the rotating ring
module pikt_cell (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             shift,
    input  pikt_pkg::entry_t d,
    output pikt_pkg::entry_t q
);
    import pikt_pkg::*;

    logic             valid_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [FREQ_W-1:0] freq_reg;
    logic [CD_W-1:0]   cd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (shift)
        begin
            valid_reg <= d.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            key_reg  <= d.key;
            freq_reg <= d.freq;
            cd_reg   <= d.cd;
        end
    end

    assign q.valid = valid_reg;
    assign q.key   = key_reg;
    assign q.freq  = freq_reg;
    assign q.cd    = cd_reg;

endmodule

[rtl/core/pikt_alu.sv]
// per-entry update and match logic at the head of the ring
module pikt_alu (
    input  logic [pikt_pkg::FUNC_W-1:0] op,
    input  logic [pikt_pkg::FREQ_W-1:0] freq,
    input  logic [pikt_pkg::KEY_W-1:0]  key,
    input  logic [7:0]                  mask,
    input  pikt_pkg::entry_t            head,
    input  pikt_pkg::scan_t             flags_in,
    output pikt_pkg::entry_t            tail,
    output pikt_pkg::scan_t             flags_out
);
    import pikt_pkg::*;

    logic same_freq;
    logic same_key;
    logic pocsag_key;
    logic flex_key;
    logic low_match;
    logic expired;

    assign same_freq  = (head.freq == freq);
    assign same_key   = (head.key == key);
    assign pocsag_key = (head.key > KEY_SPLIT);
    assign flex_key   = (head.key < KEY_SPLIT);
    assign low_match  = ((key[7:0] & mask) == (head.key[7:0] & mask));
    assign expired    = head.valid && (head.cd == '0);

    always_comb
    begin
        tail      = head;
        flags_out = flags_in;
        case (op)
            FN_INS_FLEX, FN_INS_POCSAG:
            begin
                if (head.valid && same_key && same_freq)
                begin
                    flags_out.dup = 1'b1;
                end
                else if (!head.valid && !flags_in.dup && !flags_in.placed)
                begin
                    tail.valid       = 1'b1;
                    tail.key         = key;
                    tail.freq        = freq;
                    tail.cd          = (op == FN_INS_FLEX) ? FLEX_RELOAD : POCSAG_RELOAD;
                    flags_out.placed = 1'b1;
                end
            end
            FN_ACTIVITY:
            begin
                if (head.valid && same_freq)
                begin
                    if (pocsag_key)
                    begin
                        if (same_key)
                        begin
                            tail.cd = POCSAG_RELOAD;
                        end
                    end
                    else if (low_match)
                    begin
                        tail.cd = FLEX_RELOAD;
                    end
                end
            end
            FN_TICK:
            begin
                if (head.valid && (head.cd != '0))
                begin
                    tail.cd = head.cd - 8'd1;
                end
            end
            FN_QRY_FLEX:
            begin
                if (expired && flex_key && low_match)
                begin
                    flags_out.found = 1'b1;
                end
            end
            FN_QRY_POCSAG:
            begin
                if (expired && pocsag_key)
                begin
                    flags_out.found = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

[rtl/core/pager_idle_keepalive_table.sv]
// top level: request capture, ring of entry cells, head update and result register
// a request is accepted in idle; the scan state then rotates the ring one entry per
//   cycle through the head update logic for one full pass, and the done state loads
//   the result register once the output is free; only then is a new request taken
// reset: table empty, configuration registers zero, no result pending
module pager_idle_keepalive_table (
    input  logic                              clk,
    input  logic                              rst_n,
    pikt_in_if.sink                           in_ch,
    pikt_out_if.source                        out_ch,
    input  logic                              cfg_we,
    input  logic [pikt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pikt_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import pikt_pkg::*;

    state_t state_reg, state_next;

    logic [2:0]        collapse_reg;
    logic              synced_mode_reg;
    logic [FREQ_W-1:0] synced_freq_reg;

    logic [FUNC_W-1:0] op_reg;
    logic [FREQ_W-1:0] freq_reg;
    logic [KEY_W-1:0]  key_reg;
    logic              skip_reg;
    logic [IDX_W-1:0]  cnt_reg;
    scan_t             scan_reg;
    logic [FREQ_W-1:0] hit_freq_reg;
    logic [KEY_W-1:0]  hit_key_reg;

    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [FREQ_W-1:0]   out_freq_reg;
    logic [KEY_W-1:0]    out_key_reg;

    logic in_ready;
    logic shift;
    logic load_out;
    logic accept;
    logic last_step;
    logic out_free;

    logic [FUNC_W-1:0]   op_eff;
    logic [7:0]          mask;
    entry_t              ring_q [TABLE_DEPTH];
    entry_t              alu_tail;
    scan_t               scan_next;
    logic [STATUS_W-1:0] final_status;

    assign accept    = in_ch.valid && in_ready;
    assign last_step = (cnt_reg == IDX_W'(TABLE_DEPTH - 1));
    assign out_free  = !out_valid_reg || out_ch.ready;
    assign op_eff    = skip_reg ? FN_NOP : op_reg;
    assign mask      = low_mask(collapse_reg);

    // ring of cells, head feeds the update logic, update logic feeds the tail
    genvar gi;
    generate
        for (gi = 0; gi < TABLE_DEPTH; gi++)
        begin : g_ring
            entry_t cell_d;
            if (gi == TABLE_DEPTH - 1)
            begin : g_tail
                assign cell_d = alu_tail;
            end
            else
            begin : g_link
                assign cell_d = ring_q[gi + 1];
            end
            pikt_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .shift (shift),
                .d     (cell_d),
                .q     (ring_q[gi])
            );
        end
    endgenerate

    pikt_alu u_alu (
        .op        (op_eff),
        .freq      (freq_reg),
        .key       (key_reg),
        .mask      (mask),
        .head      (ring_q[0]),
        .flags_in  (scan_reg),
        .tail      (alu_tail),
        .flags_out (scan_next)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (last_step)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        in_ready = 1'b0;
        shift    = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
            end
            S_SCAN:
            begin
                shift = 1'b1;
            end
            S_DONE:
            begin
                load_out = out_free;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            collapse_reg    <= '0;
            synced_mode_reg <= 1'b0;
            synced_freq_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_COLLAPSE:    collapse_reg    <= cfg_data[2:0];
                CFG_SYNCED_MODE: synced_mode_reg <= cfg_data[0];
                CFG_SYNCED_FREQ: synced_freq_reg <= cfg_data[FREQ_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // request capture and scan bookkeeping
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            scan_reg <= '0;
            skip_reg <= 1'b0;
            op_reg   <= FN_NOP;
        end
        else if (accept)
        begin
            cnt_reg  <= '0;
            scan_reg <= '0;
            op_reg   <= in_ch.func;
            skip_reg <= (in_ch.func == FN_INS_FLEX) && synced_mode_reg
                        && (in_ch.freq == synced_freq_reg);
        end
        else if (shift)
        begin
            cnt_reg  <= cnt_reg + IDX_W'(1);
            scan_reg <= scan_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            freq_reg     <= in_ch.freq;
            key_reg      <= in_ch.key;
            hit_freq_reg <= '0;
            hit_key_reg  <= '0;
        end
        else if (shift && scan_next.found && !scan_reg.found)
        begin
            hit_freq_reg <= ring_q[0].freq;
            hit_key_reg  <= ring_q[0].key;
        end
    end

    always_comb
    begin
        case (op_reg)
            FN_INS_FLEX, FN_INS_POCSAG:
            begin
                if (skip_reg)
                begin
                    final_status = STAT_SYNCED;
                end
                else if (scan_reg.dup)
                begin
                    final_status = STAT_DUP;
                end
                else if (scan_reg.placed)
                begin
                    final_status = STAT_OK;
                end
                else
                begin
                    final_status = STAT_FULL;
                end
            end
            FN_QRY_FLEX, FN_QRY_POCSAG:
            begin
                final_status = scan_reg.found ? STAT_OK : STAT_NONE;
            end
            default:
            begin
                final_status = STAT_OK;
            end
        endcase
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_status_reg <= final_status;
            out_freq_reg   <= hit_freq_reg;
            out_key_reg    <= hit_key_reg;
        end
    end

    assign in_ch.ready       = in_ready;
    assign out_ch.valid      = out_valid_reg;
    assign out_ch.status     = out_status_reg;
    assign out_ch.found_freq = out_freq_reg;
    assign out_ch.found_key  = out_key_reg;

endmodule
